### src/ffha_pkg.sv
// ============================================================================
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ============================================================================
package ffha_pkg;

    localparam int unsigned TOT_W    = 21;   // width of the byte totals
    localparam int unsigned REQ_W    = 21;   // width of request_size
    localparam int unsigned ADDR_W   = 32;   // width of addresses
    localparam int unsigned STAT_W   = 2;    // width of status
    localparam int unsigned NEED_W   = 22;   // rounded request, holds 2^21
    localparam logic [ADDR_W-1:0] HEAP_BASE_RESET = 32'h0010_0000;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_OOM     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_NULL    = 2'd3
    } res_status_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_START, S_SCAN, S_FAIL, S_APLAN, S_FNEXT,
        S_FPLAN, S_SHIFT, S_WTAIL, S_WHEAD, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        C_NONE, C_INIT, C_LOAD, C_SCAN, C_FAIL, C_APLAN, C_FNEXT,
        C_FPLAN, C_SHIFT, C_WTAIL, C_WHEAD, C_OUT
    } cmd_t;

    typedef struct packed {
        logic is_free;     // current request is a free
        logic null_free;   // free of the null address
        logic scan_hit;    // entry under check matches
        logic scan_done;   // walk ran past the last entry
        logic split;       // allocate splits the found region
        logic need_shift;  // plan needs table entries moved
        logic shift_done;  // move sweep finished
        logic out_full;    // result register still held
    } dp_status_t;

endpackage

### src/ffha_ctrl.sv
// ============================================================================
// ffha_ctrl
// Sequencer: walks each request through search, plan, move, write, result.
// ============================================================================
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = C_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd        = C_INIT;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd        = C_LOAD;
                    state_next = S_START;
                end
            end
            S_START: begin
                state_next = stat.null_free ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                cmd = C_SCAN;
                if (stat.scan_hit) begin
                    state_next = stat.is_free ? S_FNEXT : S_APLAN;
                end else if (stat.scan_done) begin
                    state_next = S_FAIL;
                end
            end
            S_FAIL: begin
                cmd        = C_FAIL;
                state_next = S_DONE;
            end
            S_APLAN: begin
                cmd = C_APLAN;
                if (stat.need_shift) begin
                    state_next = S_SHIFT;
                end else if (stat.split) begin
                    state_next = S_WTAIL;
                end else begin
                    state_next = S_WHEAD;
                end
            end
            S_FNEXT: begin
                cmd        = C_FNEXT;
                state_next = S_FPLAN;
            end
            S_FPLAN: begin
                cmd        = C_FPLAN;
                state_next = stat.need_shift ? S_SHIFT : S_WHEAD;
            end
            S_SHIFT: begin
                cmd = C_SHIFT;
                if (stat.shift_done) begin
                    state_next = stat.is_free ? S_WHEAD : S_WTAIL;
                end
            end
            S_WTAIL: begin
                cmd        = C_WTAIL;
                state_next = S_WHEAD;
            end
            S_WHEAD: begin
                cmd        = C_WHEAD;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!stat.out_full) begin
                    cmd        = C_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

### src/ffha_datapath.sv
// ============================================================================
// ffha_datapath
// Region table memory, search walk, move engine, totals and result register.
// ============================================================================
module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = 1048576,
    parameter int unsigned HEADER_BYTES = 12,
    parameter int unsigned MAX_REGIONS  = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output dp_status_t        stat,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  logic              in_func,
    input  logic [REQ_W-1:0]  in_size,
    input  logic [ADDR_W-1:0] in_addr,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [ADDR_W-1:0] m_address,
    output logic [STAT_W-1:0] m_status,
    output logic [TOT_W-1:0]  m_used,
    output logic [TOT_W-1:0]  m_free
);

    localparam int unsigned SZ_W = $clog2(HEAP_BYTES + 1);
    localparam int unsigned CW   = ((SZ_W > NEED_W) ? SZ_W : NEED_W) + 1;
    localparam int unsigned AW   = $clog2(MAX_REGIONS);
    localparam int unsigned NW   = AW + 1;
    localparam logic [CW-1:0]     H_C   = CW'(HEADER_BYTES);
    localparam logic [ADDR_W-1:0] H_A   = ADDR_W'(HEADER_BYTES);
    localparam logic [NW-1:0]     MAX_N = NW'(MAX_REGIONS);

    typedef struct packed {
        logic            used;
        logic [SZ_W-1:0] off;
        logic [SZ_W-1:0] size;
    } entry_t;

    entry_t mem [MAX_REGIONS];
    entry_t rdata_reg;
    logic [AW-1:0] rd_addr, waddr;
    logic          we;
    entry_t        wdata;

    logic [ADDR_W-1:0] heap_base_reg;
    logic [NW-1:0]     count_reg;
    logic [TOT_W-1:0]  used_tot_reg, free_tot_reg;
    logic              func_reg;
    logic [ADDR_W-1:0] faddr_reg;
    logic [CW-1:0]     need_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    res_status_t       res_status_reg;

    logic [NW-1:0]     scan_idx_reg;
    logic [AW-1:0]     chk_idx_reg, found_idx_reg;
    logic              chk_valid_reg;
    entry_t            found_reg, prev_reg, next_reg;

    logic [NW-1:0]     sh_rd_reg, sh_lim_reg;
    logic [1:0]        sh_dist_reg;
    logic              sh_up_reg, pend_valid_reg;
    logic [AW-1:0]     pend_waddr_reg;
    logic [AW-1:0]     head_idx_reg, tail_idx_reg;
    entry_t            head_reg, tail_reg;

    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] m_address_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [TOT_W-1:0]  m_used_reg, m_free_reg;

    // search compare
    logic          match;
    logic [CW-1:0] need_tmp;
    always_comb begin
        need_tmp = CW'(in_size) + CW'(3);
        if (func_reg) begin
            match = (heap_base_reg + ADDR_W'(rdata_reg.off) + H_A) == faddr_reg;
        end else begin
            match = !rdata_reg.used && (CW'(rdata_reg.size) >= need_reg);
        end
    end

    // allocate plan
    logic          a_split;
    logic [NW-1:0] found_n;
    always_comb begin
        found_n = NW'(found_idx_reg);
        a_split = (CW'(found_reg.size) > need_reg + H_C + CW'(4))
                  && (count_reg < MAX_N);
    end

    // free plan
    logic          mp, mn;
    logic [NW-1:0] f_src;
    logic [1:0]    f_dist;
    logic [CW-1:0] f_size;
    always_comb begin
        mp     = (found_idx_reg != '0) && !prev_reg.used;
        mn     = (found_n + NW'(1) < count_reg) && !next_reg.used;
        f_src  = found_n + NW'(1) + NW'(mn);
        f_dist = 2'(mn) + 2'(mp);
        f_size = CW'(found_reg.size)
                 + (mp ? CW'(prev_reg.size) + H_C : '0)
                 + (mn ? CW'(next_reg.size) + H_C : '0);
    end

    logic sh_active;
    assign sh_active = sh_up_reg ? (sh_rd_reg >= sh_lim_reg) : (sh_rd_reg <= sh_lim_reg);

    always_comb begin
        stat.is_free    = func_reg;
        stat.null_free  = func_reg && (faddr_reg == '0);
        stat.scan_hit   = chk_valid_reg && match;
        stat.scan_done  = !chk_valid_reg && (scan_idx_reg >= count_reg);
        stat.split      = a_split;
        stat.need_shift = func_reg ? ((f_dist != 2'd0) && (f_src < count_reg))
                                   : (a_split && (found_n + NW'(1) < count_reg));
        stat.shift_done = !sh_active && !pend_valid_reg;
        stat.out_full   = m_tvalid_reg && !m_tready;
    end

    // memory ports
    always_comb begin
        rd_addr = (cmd == C_SHIFT) ? sh_rd_reg[AW-1:0] : scan_idx_reg[AW-1:0];
        we      = 1'b0;
        waddr   = head_idx_reg;
        wdata   = head_reg;
        case (cmd)
            C_INIT: begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{used: 1'b0, off: '0,
                          size: SZ_W'(HEAP_BYTES - HEADER_BYTES)};
            end
            C_SHIFT: begin
                we    = pend_valid_reg;
                waddr = pend_waddr_reg;
                wdata = rdata_reg;
            end
            C_WTAIL: begin
                we    = 1'b1;
                waddr = tail_idx_reg;
                wdata = tail_reg;
            end
            C_WHEAD: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd)
            C_LOAD: begin
                func_reg       <= in_func;
                faddr_reg      <= in_addr;
                need_reg       <= {need_tmp[CW-1:2], 2'b00};
                res_addr_reg   <= '0;
                res_status_reg <= (in_func && in_addr == '0) ? ST_NULL : ST_DONE;
                scan_idx_reg   <= '0;
            end
            C_SCAN: begin
                chk_idx_reg <= scan_idx_reg[AW-1:0];
                if (scan_idx_reg < count_reg) begin
                    scan_idx_reg <= scan_idx_reg + NW'(1);
                end
                if (chk_valid_reg) begin
                    if (match) begin
                        found_reg     <= rdata_reg;
                        found_idx_reg <= chk_idx_reg;
                    end else begin
                        prev_reg <= rdata_reg;
                    end
                end
            end
            C_FAIL: begin
                res_status_reg <= func_reg ? ST_UNKNOWN : ST_OOM;
            end
            C_APLAN: begin
                res_addr_reg  <= heap_base_reg + ADDR_W'(found_reg.off) + H_A;
                head_idx_reg  <= found_idx_reg;
                tail_idx_reg  <= AW'(found_n + NW'(1));
                head_reg.used <= 1'b1;
                head_reg.off  <= found_reg.off;
                head_reg.size <= a_split ? SZ_W'(need_reg) : found_reg.size;
                tail_reg.used <= 1'b0;
                tail_reg.off  <= SZ_W'(CW'(found_reg.off) + H_C + need_reg);
                tail_reg.size <= SZ_W'(CW'(found_reg.size) - need_reg - H_C);
                sh_up_reg     <= 1'b1;
                sh_rd_reg     <= count_reg - NW'(1);
                sh_lim_reg    <= found_n + NW'(1);
                sh_dist_reg   <= 2'd1;
            end
            C_FNEXT: begin
                next_reg <= rdata_reg;
            end
            C_FPLAN: begin
                head_idx_reg  <= AW'(found_n - NW'(mp));
                head_reg.used <= 1'b0;
                head_reg.off  <= mp ? prev_reg.off : found_reg.off;
                head_reg.size <= SZ_W'(f_size);
                sh_up_reg     <= 1'b0;
                sh_rd_reg     <= f_src;
                sh_lim_reg    <= count_reg - NW'(1);
                sh_dist_reg   <= f_dist;
            end
            C_SHIFT: begin
                if (sh_active) begin
                    pend_waddr_reg <= sh_up_reg ? AW'(sh_rd_reg + NW'(1))
                                                : AW'(sh_rd_reg - NW'(sh_dist_reg));
                    sh_rd_reg      <= sh_up_reg ? sh_rd_reg - NW'(1)
                                                : sh_rd_reg + NW'(1);
                end
            end
            default: begin
                found_idx_reg <= found_idx_reg;
            end
        endcase
    end

    // control and table state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= HEAP_BASE_RESET;
            count_reg      <= NW'(1);
            used_tot_reg   <= '0;
            free_tot_reg   <= TOT_W'(HEAP_BYTES - HEADER_BYTES);
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                heap_base_reg <= cfg_wdata;
            end
            chk_valid_reg  <= (cmd == C_SCAN) && (scan_idx_reg < count_reg);
            pend_valid_reg <= (cmd == C_SHIFT) && sh_active;
            if (cmd == C_APLAN) begin
                count_reg <= count_reg + NW'(a_split);
                if (a_split) begin
                    used_tot_reg <= used_tot_reg + TOT_W'(need_reg);
                    free_tot_reg <= free_tot_reg - TOT_W'(need_reg + H_C);
                end else begin
                    used_tot_reg <= used_tot_reg + TOT_W'(found_reg.size);
                    free_tot_reg <= free_tot_reg - TOT_W'(found_reg.size);
                end
            end
            if (cmd == C_FPLAN) begin
                count_reg <= count_reg - NW'(f_dist);
                if (found_reg.used) begin
                    used_tot_reg <= used_tot_reg - TOT_W'(found_reg.size);
                    free_tot_reg <= free_tot_reg + TOT_W'(found_reg.size)
                                    + TOT_W'(f_dist) * TOT_W'(HEADER_BYTES);
                end else begin
                    free_tot_reg <= free_tot_reg
                                    + TOT_W'(f_dist) * TOT_W'(HEADER_BYTES);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd == C_OUT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd == C_OUT) begin
            m_address_reg <= res_addr_reg;
            m_status_reg  <= res_status_reg;
            m_used_reg    <= used_tot_reg;
            m_free_reg    <= free_tot_reg;
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_address = m_address_reg;
    assign m_status  = m_status_reg;
    assign m_used    = m_used_reg;
    assign m_free    = m_free_reg;

endmodule

### src/first_fit_heap_allocator_unit.sv
// ============================================================================
// first_fit_heap_allocator_unit
// First-fit heap allocator with coalescing over an address-ordered region
// table; sequencer plus table datapath.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                    | tuser
//  --------+-----+---------------------------------------+-------------------
//  s_      | in  | request_size[20:0], free_address[52:21]| func (0 alloc)
//  m_      | out | address[31:0], used_bytes[52:32],      | status[1:0]
//          |     | free_bytes[73:53]                      |
//  cfg_    | in  | heap_base, written when cfg_we high    |
//
//  Each request runs a table walk, an optional move and the table writes. The
//  walk reads one table entry per cycle up to the hit (or to the end of the
//  table on a miss); a split or merge then moves the entries above the hit one
//  per cycle through the table's one read port and one write port. Walk and
//  move together cover the table at most once.
//  After reset the S_INIT state writes the initial free region before the first
//  beat is taken. A held result beat does not stop the next request from being
//  accepted; only its completion waits for m_tready.
//
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int unsigned HEAP_BYTES   = 1048576,
    parameter int unsigned HEADER_BYTES = 12,
    parameter int unsigned MAX_REGIONS  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: heap_base
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // request beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // request_size[20:0], free_address[52:21]
    input  logic [0:0]  s_tuser,    // func
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // address[31:0], used[52:32], free[73:53]
    output logic [1:0]  m_tuser     // status
);

    cmd_t       cmd;
    dp_status_t stat;

    logic [ADDR_W-1:0] m_address;
    logic [STAT_W-1:0] m_status;
    logic [TOT_W-1:0]  m_used, m_free;

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffha_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_REGIONS  (MAX_REGIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_func   (s_tuser[0]),
        .in_size   (s_tdata[20:0]),
        .in_addr   (s_tdata[52:21]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_address (m_address),
        .m_status  (m_status),
        .m_used    (m_used),
        .m_free    (m_free)
    );

    assign m_tdata = {6'd0, m_free, m_used, m_address};
    assign m_tuser = m_status;

endmodule
